[src/bifc_pkg.sv]
// types and constants shared by the backlight idle fade controller
// depends on nothing; imported by every module of the block

package bifc_pkg;

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_KEY   = 2'd1;
  localparam logic [1:0] REQ_START = 2'd2;

  localparam logic [1:0] PH_AWAKE  = 2'd0;
  localparam logic [1:0] PH_FADING = 2'd1;
  localparam logic [1:0] PH_ASLEEP = 2'd2;

  localparam logic [1:0] CFG_IDLE_TIMEOUT = 2'd0;
  localparam logic [1:0] CFG_FADE_DUR     = 2'd1;
  localparam logic [1:0] CFG_FALLBACK     = 2'd2;

  localparam logic [31:0] IDLE_TIMEOUT_RST = 32'd86400000;
  localparam logic [15:0] FADE_DUR_RST     = 16'd5000;
  localparam logic [7:0]  FALLBACK_RST     = 8'd255;

  localparam int unsigned QUO_BITS = 8;
  localparam int unsigned CNT_BITS = 3;

  typedef enum logic [1:0] {
    VAL_ZERO,
    VAL_SAVED,
    VAL_QUOT
  } val_sel_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] now_ms;
    logic [7:0]  display_brightness;
  } in_t;

  typedef struct packed {
    logic       brightness_write;
    logic [7:0] brightness_value;
    logic       panel_sleep_cmd;
    logic       panel_wake_cmd;
    logic       redraw_request;
    logic [1:0] idle_phase;
  } out_t;

  typedef struct packed {
    logic       ld_in;
    logic       ld_diff;
    logic       upd_key;
    logic       capture;
    logic       mul_en;
    logic       div_step;
    logic       ld_out;
    logic       wr;
    logic       slp;
    logic       wak;
    logic       redraw;
    val_sel_e   val_sel;
    logic [1:0] phase;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       timed_out;
    logic       fade_done;
  } sts_t;

endpackage

[src/bifc_datapath.sv]
// datapath: configuration registers, time state, elapsed-time compare,
// fade multiply and shift-subtract divider, result register; uses bifc_pkg

module bifc_datapath import bifc_pkg::*; #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  in_t         in_data_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  output out_t        out_data_o
);

  localparam int unsigned CMP_W = (TIME_BITS > 32) ? TIME_BITS : 32;
  localparam int unsigned REM_W = 24;

  logic [31:0] timeout_q;
  logic [15:0] dur_q;
  logic [7:0]  fallback_q;

  in_t                  in_q;
  logic [TIME_BITS-1:0] now_w;
  logic [TIME_BITS-1:0] last_key_q;
  logic [TIME_BITS-1:0] fade_start_q;
  logic [TIME_BITS-1:0] key_el_q;
  logic [TIME_BITS-1:0] fade_el_q;
  logic [7:0]           saved_q;
  logic [REM_W-1:0]     rem_q;
  logic [REM_W-1:0]     dvs_q;
  logic [QUO_BITS-1:0]  quo_q;
  logic [15:0]          left_w;
  logic [REM_W-1:0]     prod_w;
  logic                 sub_ok_w;
  logic [7:0]           val_w;
  out_t                 out_q;

  assign now_w    = TIME_BITS'(in_q.now_ms);
  assign left_w   = dur_q - fade_el_q[15:0];
  assign prod_w   = {16'b0, saved_q} * {8'b0, left_w};
  assign sub_ok_w = rem_q >= dvs_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q  <= IDLE_TIMEOUT_RST;
      dur_q      <= FADE_DUR_RST;
      fallback_q <= FALLBACK_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IDLE_TIMEOUT: timeout_q  <= cfg_data_i;
        CFG_FADE_DUR:     dur_q      <= cfg_data_i[15:0];
        CFG_FALLBACK:     fallback_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // architectural time state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_key_q   <= '0;
      fade_start_q <= '0;
      saved_q      <= '0;
    end else begin
      if (cmd_i.upd_key) begin
        last_key_q <= now_w;
      end
      if (cmd_i.capture) begin
        fade_start_q <= now_w;
        saved_q      <= (in_q.display_brightness == 8'd0) ? fallback_q
                                                           : in_q.display_brightness;
      end
    end
  end

  // item payload, elapsed times, divider and output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_in) begin
      in_q <= in_data_i;
    end
    if (cmd_i.ld_diff) begin
      key_el_q  <= now_w - last_key_q;
      fade_el_q <= now_w - fade_start_q;
    end
    if (cmd_i.mul_en) begin
      rem_q <= prod_w;
      dvs_q <= {1'b0, dur_q, 7'b0};
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      if (sub_ok_w) begin
        rem_q <= rem_q - dvs_q;
      end
      quo_q <= {quo_q[QUO_BITS-2:0], sub_ok_w};
      dvs_q <= dvs_q >> 1;
    end
    if (cmd_i.ld_out) begin
      out_q.brightness_write <= cmd_i.wr;
      out_q.brightness_value <= val_w;
      out_q.panel_sleep_cmd  <= cmd_i.slp;
      out_q.panel_wake_cmd   <= cmd_i.wak;
      out_q.redraw_request   <= cmd_i.redraw;
      out_q.idle_phase       <= cmd_i.phase;
    end
  end

  always_comb begin
    case (cmd_i.val_sel)
      VAL_SAVED: val_w = saved_q;
      VAL_QUOT:  val_w = quo_q;
      default:   val_w = 8'd0;
    endcase
  end

  assign sts_o.req_type  = in_q.req_type;
  assign sts_o.timed_out = CMP_W'(key_el_q) >= CMP_W'(timeout_q);
  assign sts_o.fade_done = CMP_W'(fade_el_q) >= CMP_W'(dur_q);
  assign out_data_o      = out_q;

endmodule

[src/bifc_ctrl.sv]
// controller: item sequencing, idle phase and tracking state, result valid
// uses bifc_pkg; drives the datapath through cmd_t and reads sts_t

module bifc_ctrl import bifc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIFF,
    S_EVAL,
    S_MUL,
    S_DIV,
    S_DONE
  } state_e;

  state_e              state_q;
  logic                tracking_q;
  logic [1:0]          phase_q;
  logic [CNT_BITS-1:0] cnt_q;
  logic                out_valid_q;
  logic                res_wr_q;
  logic                res_slp_q;
  logic                res_wak_q;
  logic                res_redraw_q;
  val_sel_e            res_sel_q;
  logic                is_tick;
  logic                is_key;
  logic                out_free;

  assign is_tick  = tracking_q && (sts_i.req_type == REQ_TICK);
  assign is_key   = tracking_q && (sts_i.req_type == REQ_KEY);
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      tracking_q   <= 1'b0;
      phase_q      <= PH_AWAKE;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
      res_wr_q     <= 1'b0;
      res_slp_q    <= 1'b0;
      res_wak_q    <= 1'b0;
      res_redraw_q <= 1'b0;
      res_sel_q    <= VAL_ZERO;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_DIFF;
          end
        end
        S_DIFF: begin
          state_q <= S_EVAL;
        end
        S_EVAL: begin
          res_wr_q     <= 1'b0;
          res_slp_q    <= 1'b0;
          res_wak_q    <= 1'b0;
          res_redraw_q <= 1'b0;
          res_sel_q    <= VAL_ZERO;
          state_q      <= S_DONE;
          if (sts_i.req_type == REQ_START) begin
            tracking_q <= 1'b1;
            phase_q    <= PH_AWAKE;
          end else if (is_key) begin
            if (phase_q != PH_AWAKE) begin
              res_wr_q     <= 1'b1;
              res_sel_q    <= VAL_SAVED;
              res_wak_q    <= (phase_q == PH_ASLEEP);
              res_redraw_q <= 1'b1;
              phase_q      <= PH_AWAKE;
            end
          end else if (is_tick) begin
            if (phase_q == PH_AWAKE) begin
              if (sts_i.timed_out) begin
                phase_q <= PH_FADING;
              end
            end else if (phase_q == PH_FADING) begin
              res_wr_q <= 1'b1;
              if (sts_i.fade_done) begin
                res_slp_q <= 1'b1;
                phase_q   <= PH_ASLEEP;
              end else begin
                res_sel_q <= VAL_QUOT;
                state_q   <= S_MUL;
              end
            end
          end
        end
        S_MUL: begin
          cnt_q   <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_BITS'(QUO_BITS - 1)) begin
            cnt_q   <= '0;
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.ld_in    = (state_q == S_IDLE) && in_valid_i;
    cmd_o.ld_diff  = (state_q == S_DIFF);
    cmd_o.upd_key  = (state_q == S_EVAL) &&
                     ((sts_i.req_type == REQ_START) || is_key);
    cmd_o.capture  = (state_q == S_EVAL) && is_tick && (phase_q == PH_AWAKE) &&
                     sts_i.timed_out;
    cmd_o.mul_en   = (state_q == S_MUL);
    cmd_o.div_step = (state_q == S_DIV);
    cmd_o.ld_out   = (state_q == S_DONE) && out_free;
    cmd_o.wr       = res_wr_q;
    cmd_o.slp      = res_slp_q;
    cmd_o.wak      = res_wak_q;
    cmd_o.redraw   = res_redraw_q;
    cmd_o.val_sel  = res_sel_q;
    cmd_o.phase    = phase_q;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  a_div_only_fading: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (phase_q == PH_FADING))
    else $error("divider running outside fading phase");

  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_DIV) |-> (cnt_q == '0))
    else $error("step counter not cleared outside divide");

  a_done_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !out_valid_q) |=> out_valid_q)
    else $error("result not delivered from done state");

  a_untracked_awake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !tracking_q |-> (phase_q == PH_AWAKE))
    else $error("phase left awake before tracking started");

endmodule

[src/backlight_idle_fade_controller.sv]
// top level of the backlight idle fade controller
// instantiates bifc_ctrl and bifc_datapath; uses bifc_pkg
//
//   port group   direction  handshake               payload
//   in           input      in_valid_i / in_stall_o   in_data_i (in_t)
//   out          output     out_valid_o / out_stall_i out_data_o (out_t)
//   cfg          input      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// an item passes the diff, eval and done states; a fading tick that is still dimming
// also passes the multiply and the eight one-bit-per-cycle divide steps
// a new item is taken while the previous item waits at the output register
// out stall holds a finished item in the done state until the register frees
// reset clears config to defaults, tracking off, phase awake, no pending item

module backlight_idle_fade_controller import bifc_pkg::*; #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_t        out_data_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  bifc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bifc_datapath #(
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule
